// File: rtl/core/bmp_24bit_stream_decoder_defines.svh
// ---------------------------------------------------------------------------
// BMP stream decoder assertion macros
// Concurrent assertion helpers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BMP_24BIT_STREAM_DECODER_DEFINES_SVH
`define BMP_24BIT_STREAM_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define BMPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`define BMPD_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define BMPD_ASSERT(label, prop, msg)
`define BMPD_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// File: rtl/core/bmpd_pkg.sv
// ---------------------------------------------------------------------------
// BMP stream decoder package
// Limits, header byte positions, phase and status codes, item and result types.
// ---------------------------------------------------------------------------
package bmpd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	// stored width/height must hold the limit itself
	localparam int W_BITS = $clog2(MAX_WIDTH + 1);
	localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
	// pixel counters run up to limit - 1
	localparam int X_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int Y_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int COORD_BITS = 12;

	localparam logic [7:0]  SIG_B      = 8'h42;
	localparam logic [7:0]  SIG_M      = 8'h4D;
	localparam logic [31:0] HEADER_END = 32'd28;
	localparam logic [31:0] POS_SAT    = '1;

	localparam logic [4:0] POS_SIG_0    = 5'd0;
	localparam logic [4:0] POS_SIG_1    = 5'd1;
	localparam logic [4:0] POS_OFS_0    = 5'd10;
	localparam logic [4:0] POS_OFS_1    = 5'd11;
	localparam logic [4:0] POS_OFS_2    = 5'd12;
	localparam logic [4:0] POS_OFS_3    = 5'd13;
	localparam logic [4:0] POS_W_0      = 5'd18;
	localparam logic [4:0] POS_W_1      = 5'd19;
	localparam logic [4:0] POS_W_2      = 5'd20;
	localparam logic [4:0] POS_W_3      = 5'd21;
	localparam logic [4:0] POS_H_0      = 5'd22;
	localparam logic [4:0] POS_H_1      = 5'd23;
	localparam logic [4:0] POS_H_2      = 5'd24;
	localparam logic [4:0] POS_H_3      = 5'd25;
	localparam logic [4:0] POS_PLANES_0 = 5'd26;
	localparam logic [4:0] POS_PLANES_1 = 5'd27;

	localparam logic [1:0] CH_BLUE  = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_RED   = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PIXELS  = 2'd2,
		PH_STOPPED = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_PIXEL      = 3'd0,
		ST_BAD_SIG    = 3'd1,
		ST_BAD_PLANES = 3'd2,
		ST_BAD_SIZE   = 3'd3,
		ST_BAD_OFFSET = 3'd4,
		ST_TRUNCATED  = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		status_t               status;
		logic [COORD_BITS-1:0] column;
		logic [COORD_BITS-1:0] row;
		logic [7:0]            red;
		logic [7:0]            green;
		logic [7:0]            blue;
		logic                  final_pixel;
	} result_t;

endpackage

// File: rtl/core/bmp_24bit_stream_decoder.sv
// ---------------------------------------------------------------------------
// 24-bit BMP stream decoder
// Parses a BMP file fed one byte per word and streams out its pixels. Each
// byte passes an input register, is decoded combinationally against the
// parse state and lands in a result register, so the block takes one byte
// every clock, and the byte that completes a pixel passes the input register
// and then the result register before the pixel appears; the rate drops
// below one byte per cycle only while the result register is stalled.
// A word with tuser set starts a new file. Bytes 0-1 must read "BM", bytes
// 10-13 give the pixel-data offset, 18-21 the width, 22-25 the height and
// 26-27 the plane count, which must be 1. Pixel bytes arrive blue, green,
// red; rows are bottom-up, so the first row out is height - 1, and the pad
// bytes that round each row to four bytes are dropped. Any error yields one
// status word with tlast set and halts the block until the next file; tlast
// on the input before the final pixel is reported as truncated. Bytes after
// the final pixel, and all bytes while halted, give no output.
// ---------------------------------------------------------------------------
module bmp_24bit_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] first_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [11:0] column, [23:12] row, [31:24] red,
	                               // [39:32] green, [47:40] blue
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast    // final_pixel
);
	import bmpd_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	result_t res;
	result_t out_res;
	logic    fire;
	logic    free;
	logic    res_valid;

	// pack the slave word into the item
	assign in_item.data_byte  = s_tdata;
	assign in_item.first_byte = s_tuser;
	assign in_item.last_byte  = s_tlast;

	// hold the byte until the result register has room
	bmpd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.take     (free),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	// decode one byte per cycle against the parse state while the result register is not stalled
	bmpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// hold the result word for the master side
	bmpd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res_valid (res_valid),
		.res       (res),
		.free      (free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// unpack the result word onto the master bus
	assign m_tdata = {out_res.blue, out_res.green, out_res.red, out_res.row, out_res.column};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.final_pixel;

endmodule

// File: rtl/core/bmpd_in_reg.sv
// ---------------------------------------------------------------------------
// BMP stream decoder input register
// Holds one input word until the parser consumes it.
// ---------------------------------------------------------------------------
module bmpd_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bmpd_pkg::item_t in_item,
	input  logic           take,
	output logic           fire,
	output bmpd_pkg::item_t item_s1
);
	import bmpd_pkg::*;

	logic valid_s1;

	assign fire     = valid_s1 && take;
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: rtl/core/bmpd_parser.sv
// ---------------------------------------------------------------------------
// BMP stream decoder parser
// Header field capture, checks, pixel assembly and row/column tracking.
// ---------------------------------------------------------------------------
`include "bmp_24bit_stream_decoder_defines.svh"
module bmpd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  bmpd_pkg::item_t  item,
	output logic             res_valid,
	output bmpd_pkg::result_t res
);
	import bmpd_pkg::*;

	phase_t             phase_q, cur_phase, nxt_phase;
	logic [31:0]        pos_q, cur_pos, nxt_pos;
	logic [31:0]        start_q, cur_start, nxt_start;
	logic [23:0]        gather_q, cur_gather, nxt_gather;
	logic [W_BITS-1:0]  width_q, cur_width, nxt_width;
	logic [H_BITS-1:0]  height_q, cur_height, nxt_height;
	logic [X_BITS-1:0]  pixel_x_q, cur_x, nxt_x;
	logic [Y_BITS-1:0]  pixel_y_q, cur_y, nxt_y;
	logic [1:0]         chan_q, cur_chan, nxt_chan;
	logic [1:0]         pad_q, cur_pad, nxt_pad;
	logic [7:0]         blue_q, cur_blue, nxt_blue;
	logic [7:0]         green_q, cur_green, nxt_green;
	logic [31:0]        full_word;
	status_t            err;
	logic               pix;
	logic               fin;
	logic               active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			start_q   <= '0;
			gather_q  <= '0;
			width_q   <= '0;
			height_q  <= '0;
			pixel_x_q <= '0;
			pixel_y_q <= '0;
			chan_q    <= '0;
			pad_q     <= '0;
			blue_q    <= '0;
			green_q   <= '0;
		end else if (fire) begin
			phase_q   <= nxt_phase;
			pos_q     <= nxt_pos;
			start_q   <= nxt_start;
			gather_q  <= nxt_gather;
			width_q   <= nxt_width;
			height_q  <= nxt_height;
			pixel_x_q <= nxt_x;
			pixel_y_q <= nxt_y;
			chan_q    <= nxt_chan;
			pad_q     <= nxt_pad;
			blue_q    <= nxt_blue;
			green_q   <= nxt_green;
		end
	end

	always_comb begin
		// a first byte restarts the parse from a cleared state
		cur_phase  = item.first_byte ? PH_HEADER : phase_q;
		cur_pos    = item.first_byte ? '0 : pos_q;
		cur_start  = item.first_byte ? '0 : start_q;
		cur_gather = item.first_byte ? '0 : gather_q;
		cur_width  = item.first_byte ? '0 : width_q;
		cur_height = item.first_byte ? '0 : height_q;
		cur_x      = item.first_byte ? '0 : pixel_x_q;
		cur_y      = item.first_byte ? '0 : pixel_y_q;
		cur_chan   = item.first_byte ? '0 : chan_q;
		cur_pad    = item.first_byte ? '0 : pad_q;
		cur_blue   = item.first_byte ? '0 : blue_q;
		cur_green  = item.first_byte ? '0 : green_q;

		nxt_phase  = cur_phase;
		nxt_pos    = cur_pos;
		nxt_start  = cur_start;
		nxt_gather = cur_gather;
		nxt_width  = cur_width;
		nxt_height = cur_height;
		nxt_x      = cur_x;
		nxt_y      = cur_y;
		nxt_chan   = cur_chan;
		nxt_pad    = cur_pad;
		nxt_blue   = cur_blue;
		nxt_green  = cur_green;

		full_word = {item.data_byte, cur_gather};
		err       = ST_PIXEL;
		pix       = 1'b0;
		fin       = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		active    = (cur_phase == PH_HEADER) || (cur_phase == PH_PIXELS);

		if (active) begin
			if (cur_pos != POS_SAT) begin
				nxt_pos = cur_pos + 32'd1;
			end

			if (cur_phase == PH_HEADER) begin
				// header never runs past byte 27, so five bits select the byte
				unique case (cur_pos[4:0]) inside
					POS_SIG_0: begin
						if (item.data_byte != SIG_B) err = ST_BAD_SIG;
					end
					POS_SIG_1: begin
						if (item.data_byte != SIG_M) err = ST_BAD_SIG;
					end
					POS_OFS_0: nxt_start[7:0]   = item.data_byte;
					POS_OFS_1: nxt_start[15:8]  = item.data_byte;
					POS_OFS_2: nxt_start[23:16] = item.data_byte;
					POS_OFS_3: nxt_start[31:24] = item.data_byte;
					POS_W_0, POS_H_0, POS_PLANES_0: begin
						nxt_gather = {16'd0, item.data_byte};
					end
					POS_W_1, POS_H_1: nxt_gather[15:8]  = item.data_byte;
					POS_W_2, POS_H_2: nxt_gather[23:16] = item.data_byte;
					POS_W_3: begin
						if (full_word == '0 || full_word > 32'(MAX_WIDTH)) begin
							err = ST_BAD_SIZE;
						end else begin
							nxt_width = W_BITS'(full_word);
						end
					end
					POS_H_3: begin
						if (full_word == '0 || full_word > 32'(MAX_HEIGHT)) begin
							err = ST_BAD_SIZE;
						end else begin
							nxt_height = H_BITS'(full_word);
						end
					end
					POS_PLANES_1: begin
						if ({item.data_byte, cur_gather[7:0]} != 16'd1) begin
							err = ST_BAD_PLANES;
						end else if (cur_start < HEADER_END) begin
							err = ST_BAD_OFFSET;
						end else begin
							nxt_phase = PH_PIXELS;
							nxt_x     = '0;
							nxt_y     = Y_BITS'(cur_height - H_BITS'(1));
							nxt_chan  = CH_BLUE;
							nxt_pad   = '0;
						end
					end
					default: ;
				endcase
			end else if (cur_pos >= cur_start) begin
				if (cur_pad != 2'd0) begin
					nxt_pad = cur_pad - 2'd1;
				end else begin
					case (cur_chan)
						CH_BLUE: begin
							nxt_blue = item.data_byte;
							nxt_chan = CH_GREEN;
						end
						CH_GREEN: begin
							nxt_green = item.data_byte;
							nxt_chan  = CH_RED;
						end
						default: begin
							nxt_chan = CH_BLUE;
							pix      = 1'b1;
						end
					endcase
				end
			end

			if (pix) begin
				if (W_BITS'(cur_x) + W_BITS'(1) >= cur_width) begin
					if (cur_y == '0) begin
						fin       = 1'b1;
						nxt_phase = PH_STOPPED;
					end else begin
						nxt_x   = '0;
						nxt_y   = cur_y - Y_BITS'(1);
						// 24-bit rows pad by width mod 4 bytes
						nxt_pad = 2'(cur_width);
					end
				end else begin
					nxt_x = cur_x + X_BITS'(1);
				end
			end

			if (err != ST_PIXEL) begin
				res_valid       = 1'b1;
				res.status      = err;
				res.final_pixel = 1'b1;
				nxt_phase       = PH_STOPPED;
			end else if (pix && !(item.last_byte && !fin)) begin
				res_valid       = 1'b1;
				res.status      = ST_PIXEL;
				res.column      = COORD_BITS'(cur_x);
				res.row         = COORD_BITS'(cur_y);
				res.red         = item.data_byte;
				res.green       = cur_green;
				res.blue        = cur_blue;
				res.final_pixel = fin;
			end else if (item.last_byte) begin
				res_valid       = 1'b1;
				res.status      = ST_TRUNCATED;
				res.final_pixel = 1'b1;
				nxt_phase       = PH_STOPPED;
			end
		end
	end

	`BMPD_ASSERT(a_final_stops, fire && res_valid && res.final_pixel |=> phase_q == PH_STOPPED, "final result did not stop the parse")
	`BMPD_ASSERT(a_x_in_row, phase_q == PH_PIXELS |-> W_BITS'(pixel_x_q) < width_q, "column beyond image width")
	`BMPD_ASSERT(a_y_in_image, phase_q == PH_PIXELS |-> H_BITS'(pixel_y_q) < height_q, "row beyond image height")
	`BMPD_ASSERT_NEVER(a_quiet_when_halted, fire && res_valid && !item.first_byte && (phase_q == PH_IDLE || phase_q == PH_STOPPED), "result while halted")

endmodule

// File: rtl/core/bmpd_out_reg.sv
// ---------------------------------------------------------------------------
// BMP stream decoder output register
// Holds one result word until the downstream side takes it.
// ---------------------------------------------------------------------------
module bmpd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              res_valid,
	input  bmpd_pkg::result_t res,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output bmpd_pkg::result_t out_res
);
	import bmpd_pkg::*;

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= res_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_res <= res;
		end
	end

endmodule
